// ----- sv/hrbs_pkg.sv -----
`default_nettype none
package hrbs_pkg;
	localparam int MaxRegions = 64;
	localparam int PositionBits = 24;
	localparam int CfgWidth = 16;

	localparam logic [1:0] StatusPos = 2'd0;
	localparam logic [1:0] StatusDone = 2'd1;
	localparam logic [1:0] StatusAdded = 2'd2;
	localparam logic [1:0] StatusFull = 2'd3;

	localparam logic [1:0] RegSpanBefore = 2'd0;
	localparam logic [1:0] RegSpanAfter = 2'd1;
	localparam logic [1:0] RegProgLimit = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INS_RD,
		ST_INS_WR,
		ST_NEXT_RD,
		ST_NEXT_EVAL,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- sv/hot_region_byte_scanner.sv -----
// Hot region byte scanner.
// Input words arrive on s_axis_*: tdata holds opcode in bit 0 and offset above it.
// Opcode 0 adds a hot offset as a region window; opcode 1 asks for the next
// position and progress to try. Each input word yields exactly one output word
// on m_axis_*: tdata holds status, position and progress from the lowest bit up.
// Configuration words on cfg_* write span_before (0), span_after (1) and
// progress_limit (2); write them only while the block is idle.
// The region table sits in one memory with a registered read port, and one
// sequencer walks it an entry at a time. An add searches the regions in order
// and, on an insert, moves each later region up one entry before writing the
// new one. A next visits regions from the scan point until one gives a
// position or the table ends.
// The block takes no new word until the output register has been emptied, so a
// stalled receiver holds the result and blocks the input side.
// Reset empties the table, sets the scan to its start and loads the register
// defaults; the table contents need no clearing.
`default_nettype none
module hot_region_byte_scanner #(
	parameter int MAX_REGIONS = hrbs_pkg::MaxRegions,
	parameter int POSITION_BITS = hrbs_pkg::PositionBits
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [31:0] s_axis_tdata, // opcode, offset[23:0], zero fill
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // status[1:0], position[23:0], progress[15:0], zero fill
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	localparam int IW = $clog2(MAX_REGIONS);
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam int PW = POSITION_BITS;
	localparam int EW = 3 * PW + 16;
	localparam logic [PW-1:0] PosMax = {PW{1'b1}};

	hrbs_pkg::state_t state_q, state_d;
	logic [EW-1:0] mem_q [MAX_REGIONS];
	logic [EW-1:0] rd_q;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] wr_data;
	logic wr_en;

	logic [15:0] span_before_q, span_after_q, limit_q;
	logic [CW-1:0] count_q, count_d, scan_q, scan_d, idx_q, idx_d;
	logic [PW-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [1:0] st_q, st_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [15:0] prog_q, prog_d;
	logic ovalid_q, ovalid_d;
	logic in_fire;

	logic [PW-1:0] r_start, r_end, r_cur;
	logic [15:0] r_prog, p1;
	logic [PW-1:0] c1;
	logic [PW+16:0] sum;
	logic [PW-1:0] off;

	assign r_start = rd_q[EW-1 -: PW];
	assign r_end = rd_q[EW-1-PW -: PW];
	assign r_cur = rd_q[EW-1-2*PW -: PW];
	assign r_prog = rd_q[15:0];

	assign off = PW'(s_axis_tdata[24:1]);
	assign sum = {17'd0, off} + {{(PW + 1){1'b0}}, span_after_q};
	assign s_axis_tready = (state_q == hrbs_pkg::ST_IDLE) && !ovalid_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {6'd0, prog_q, 24'(pos_q), st_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrbs_pkg::ST_IDLE;
			span_before_q <= 16'd16;
			span_after_q <= 16'd16;
			limit_q <= 16'd256;
			count_q <= '0;
			scan_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			scan_q <= scan_d;
			ovalid_q <= ovalid_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					hrbs_pkg::RegSpanBefore: span_before_q <= cfg_data;
					hrbs_pkg::RegSpanAfter: span_after_q <= cfg_data;
					hrbs_pkg::RegProgLimit: limit_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		lo_q <= lo_d;
		hi_q <= hi_d;
		st_q <= st_d;
		pos_q <= pos_d;
		prog_q <= prog_d;
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		scan_d = scan_q;
		idx_d = idx_q;
		lo_d = lo_q;
		hi_d = hi_q;
		st_d = st_q;
		pos_d = pos_q;
		prog_d = prog_q;
		ovalid_d = ovalid_q;
		rd_addr = idx_q[IW-1:0];
		wr_addr = idx_q[IW-1:0];
		wr_data = rd_q;
		wr_en = 1'b0;
		p1 = r_prog;
		c1 = r_cur;
		if (ovalid_q && m_axis_tready) begin
			ovalid_d = 1'b0;
		end
		unique case (state_q)
			hrbs_pkg::ST_IDLE: begin
				if (in_fire) begin
					idx_d = '0;
					pos_d = '0;
					prog_d = '0;
					lo_d = ({16'd0, off} >= {{PW{1'b0}}, span_before_q}) ?
						off - PW'(span_before_q) : '0;
					hi_d = (sum > {17'd0, PosMax}) ? PosMax : sum[PW-1:0];
					if (s_axis_tdata[0]) begin
						idx_d = scan_q;
						state_d = hrbs_pkg::ST_NEXT_RD;
					end else begin
						scan_d = '0;
						state_d = hrbs_pkg::ST_ADD_RD;
					end
				end
			end
			hrbs_pkg::ST_ADD_RD: begin
				if (idx_q == count_q) begin
					if (count_q == CW'(MAX_REGIONS)) begin
						st_d = hrbs_pkg::StatusFull;
						state_d = hrbs_pkg::ST_OUT;
					end else begin
						wr_en = 1'b1;
						wr_data = {lo_q, hi_q, lo_q, 16'd0};
						count_d = count_q + 1'b1;
						st_d = hrbs_pkg::StatusAdded;
						state_d = hrbs_pkg::ST_OUT;
					end
				end else begin
					state_d = hrbs_pkg::ST_ADD_CMP;
				end
			end
			hrbs_pkg::ST_ADD_CMP: begin
				if (lo_q < r_start) begin
					if (count_q == CW'(MAX_REGIONS)) begin
						st_d = hrbs_pkg::StatusFull;
						state_d = hrbs_pkg::ST_OUT;
					end else begin
						if (r_start < hi_q) begin
							hi_d = r_start;
						end
						idx_d = count_q - 1'b1;
						rd_addr = IW'(count_q - 1'b1);
						state_d = hrbs_pkg::ST_SHIFT_WR;
						scan_d = idx_q;
					end
				end else if (lo_q <= r_end) begin
					if (hi_q > r_end) begin
						wr_en = 1'b1;
						wr_data = {r_start, hi_q, r_cur, r_prog};
					end
					st_d = hrbs_pkg::StatusAdded;
					state_d = hrbs_pkg::ST_OUT;
				end else begin
					idx_d = idx_q + 1'b1;
					rd_addr = IW'(idx_q + 1'b1);
					state_d = hrbs_pkg::ST_ADD_RD;
				end
			end
			hrbs_pkg::ST_SHIFT_WR: begin
				wr_en = 1'b1;
				wr_addr = IW'(idx_q + 1'b1);
				wr_data = rd_q;
				if (idx_q == scan_q) begin
					state_d = hrbs_pkg::ST_INS_WR;
				end else begin
					idx_d = idx_q - 1'b1;
					rd_addr = IW'(idx_q - 1'b1);
					state_d = hrbs_pkg::ST_SHIFT_RD;
				end
			end
			hrbs_pkg::ST_SHIFT_RD: begin
				rd_addr = idx_q[IW-1:0];
				state_d = hrbs_pkg::ST_SHIFT_WR;
			end
			hrbs_pkg::ST_INS_WR: begin
				wr_en = 1'b1;
				wr_data = {lo_q, hi_q, lo_q, 16'd0};
				count_d = count_q + 1'b1;
				scan_d = '0;
				st_d = hrbs_pkg::StatusAdded;
				state_d = hrbs_pkg::ST_OUT;
			end
			hrbs_pkg::ST_INS_RD: begin
				state_d = hrbs_pkg::ST_OUT;
			end
			hrbs_pkg::ST_NEXT_RD: begin
				if (idx_q >= count_q) begin
					scan_d = idx_q;
					st_d = hrbs_pkg::StatusDone;
					state_d = hrbs_pkg::ST_OUT;
				end else begin
					state_d = hrbs_pkg::ST_NEXT_EVAL;
				end
			end
			hrbs_pkg::ST_NEXT_EVAL: begin
				if (r_prog >= limit_q) begin
					p1 = '0;
					if (r_cur < r_end) begin
						c1 = r_cur + 1'b1;
					end
				end
				if (c1 >= r_end) begin
					wr_en = 1'b1;
					wr_data = {r_start, r_end, c1, p1};
					idx_d = idx_q + 1'b1;
					rd_addr = IW'(idx_q + 1'b1);
					state_d = hrbs_pkg::ST_NEXT_RD;
				end else begin
					wr_en = 1'b1;
					wr_data = {r_start, r_end, c1, p1 + 1'b1};
					scan_d = idx_q;
					st_d = hrbs_pkg::StatusPos;
					pos_d = c1;
					prog_d = p1;
					state_d = hrbs_pkg::ST_OUT;
				end
			end
			hrbs_pkg::ST_OUT: begin
				ovalid_d = 1'b1;
				state_d = hrbs_pkg::ST_IDLE;
			end
			default: state_d = hrbs_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire
